// ----- design/mmn_pkg.sv -----
// Package for the min-max normaliser: beat payload types, controller command and
// status structs, controller state encoding and fixed field widths.
// No dependencies.
package mmn_pkg;

	localparam int VALUE_W       = 32;
	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int ELEM_INDEX_W  = 10;
	localparam int CFG_W         = 5;

	// shared serial divider: quotient/dividend shift register and step counter
	localparam int DIV_W      = (FRACTION_BITS > ELEM_INDEX_W) ? FRACTION_BITS : ELEM_INDEX_W;
	localparam int DIV_STEP_W = $clog2(DIV_W + 1);

	localparam int DEF_MAX_ATTRIBUTES = 16;
	localparam int DEF_MAX_ELEMENTS   = 1024;

	localparam logic [CFG_W-1:0]   NUM_ATTR_RESET = CFG_W'(1);
	localparam logic [FRAC_W-1:0]  FRAC_HALF      = FRAC_W'(1) << (FRACTION_BITS - 1);
	localparam logic [FRAC_W-1:0]  FRAC_ONE       = FRAC_W'(1) << FRACTION_BITS;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic                      first;
		logic signed [VALUE_W-1:0] value;
		logic                      present;
		logic [ELEM_INDEX_W-1:0]   elem_index;
	} in_item_t;

	typedef struct packed {
		logic [FRAC_W-1:0]         norm_fraction;
		logic signed [VALUE_W-1:0] raw_value;
		logic                      elem_present;
		logic                      passed_through;
		logic                      index_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_FETCH,
		ST_COLUMN,
		ST_CLASSIFY,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_load;
		logic mem_read;
		logic set_error;
		logic div_mod_start;
		logic col_from_rem;
		logic classify;
		logic div_frac_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_error;
		logic need_div;
		logic div_busy;
		logic div_last;
	} sts_t;

endpackage

// ----- design/mmn_divider.sv -----
// Serial restoring divider, one quotient bit per cycle, shared between the
// column remainder and the fraction quotient. Depends on mmn_pkg.
module mmn_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mmn_pkg::VALUE_W-1:0]   rem_init,
	input  logic [mmn_pkg::DIV_W-1:0]     quo_init,
	input  logic [mmn_pkg::VALUE_W-1:0]   divisor,
	input  logic [mmn_pkg::DIV_STEP_W-1:0] steps,
	output logic                          busy,
	output logic                          last,
	output logic [mmn_pkg::VALUE_W-1:0]   rem,
	output logic [mmn_pkg::DIV_W-1:0]     quo
);
	import mmn_pkg::*;

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [VALUE_W-1:0]    rem_q;
	logic [VALUE_W-1:0]    dvs_q;
	logic [DIV_W-1:0]      quo_q;
	logic [VALUE_W:0]      trial;
	logic [VALUE_W:0]      diff;
	logic                  ge;

	// shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_STEP_W'(1);
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign last = busy_q && (cnt_q == DIV_STEP_W'(1));
	assign rem  = rem_q;
	assign quo  = quo_q;

endmodule

// ----- design/mmn_datapath.sv -----
// Datapath of the min-max normaliser: value store, column extremes, input and
// result registers, shared divider. Depends on mmn_pkg and mmn_divider.
module mmn_datapath #(
	parameter int MAX_ATTRIBUTES = mmn_pkg::DEF_MAX_ATTRIBUTES,
	parameter int MAX_ELEMENTS   = mmn_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mmn_pkg::CFG_W-1:0] cfg_wdata,
	input  mmn_pkg::in_item_t         in_item,
	input  mmn_pkg::cmd_t             cmd,
	output mmn_pkg::sts_t             sts,
	output mmn_pkg::out_item_t        out_item
);
	import mmn_pkg::*;

	localparam int AW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int COL_W = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;

	logic [CFG_W-1:0]          natt_q;
	logic [CFG_W-1:0]          natt;
	in_item_t                  in_q;
	logic [CW-1:0]             load_count_q;
	logic [COL_W-1:0]          ptr_q;
	logic [MAX_ATTRIBUTES-1:0] col_vld_q;
	logic signed [VALUE_W-1:0] col_min_q [MAX_ATTRIBUTES];
	logic signed [VALUE_W-1:0] col_max_q [MAX_ATTRIBUTES];
	logic [VALUE_W:0]          store [MAX_ELEMENTS];
	logic [VALUE_W:0]          rd_q;

	logic                      first_ld;
	logic [CW-1:0]             count_base;
	logic [COL_W-1:0]          ptr_base;
	logic [COL_W-1:0]          ptr_wrap;
	logic [COL_W-1:0]          ptr_next;
	logic [MAX_ATTRIBUTES-1:0] vld_base;
	logic [MAX_ATTRIBUTES-1:0] vld_next;
	logic                      store_full;
	logic [COL_W-1:0]          col_sel;
	logic signed [VALUE_W-1:0] mn;
	logic signed [VALUE_W-1:0] mx;
	logic signed [VALUE_W-1:0] rd_val;

	logic                      few_rows;
	logic                      pass;
	logic                      need_div;
	logic [FRAC_W-1:0]         frac_fix;
	logic [VALUE_W:0]          num;
	logic [VALUE_W:0]          den;

	logic                      res_err_q;
	logic                      res_pass_q;
	logic                      res_quot_q;
	logic [FRAC_W-1:0]         res_frac_q;
	out_item_t                 out_q;

	logic                      div_start;
	logic [VALUE_W-1:0]        div_rem_init;
	logic [DIV_W-1:0]          div_quo_init;
	logic [VALUE_W-1:0]        div_divisor;
	logic [DIV_STEP_W-1:0]     div_steps;
	logic                      div_busy;
	logic                      div_last;
	logic [VALUE_W-1:0]        div_rem;
	logic [DIV_W-1:0]          div_quo;

	// column count: zero acts as one, clamp to the column store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			natt_q <= NUM_ATTR_RESET;
		end else if (cfg_we) begin
			natt_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (natt_q == '0) begin
			natt = CFG_W'(1);
		end else if (int'(natt_q) > MAX_ATTRIBUTES) begin
			natt = CFG_W'(MAX_ATTRIBUTES);
		end else begin
			natt = natt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_item;
		end
	end

	// load path: a first beat clears count, pointer and extremes before the write
	assign first_ld   = cmd.do_load && in_q.first;
	assign count_base = first_ld ? '0 : load_count_q;
	assign ptr_base   = first_ld ? '0 : ptr_q;
	assign vld_base   = first_ld ? '0 : col_vld_q;
	assign store_full = int'(count_base) == MAX_ELEMENTS;
	assign ptr_wrap   = (int'(ptr_base) >= int'(natt)) ? '0 : ptr_base;
	assign ptr_next   = (int'(ptr_wrap) + 1 >= int'(natt)) ? '0 : COL_W'(int'(ptr_wrap) + 1);

	assign col_sel = cmd.col_from_rem ? div_rem[COL_W-1:0] : ptr_wrap;
	assign mn      = vld_base[col_sel] ? col_min_q[col_sel] : VALUE_MAX;
	assign mx      = vld_base[col_sel] ? col_max_q[col_sel] : VALUE_MIN;

	always_comb begin
		vld_next = vld_base;
		if (!store_full && in_q.present) begin
			vld_next[col_sel] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			ptr_q        <= '0;
			col_vld_q    <= '0;
		end else if (cmd.do_load) begin
			col_vld_q <= vld_next;
			if (store_full) begin
				load_count_q <= count_base;
				ptr_q        <= ptr_base;
			end else begin
				load_count_q <= count_base + CW'(1);
				ptr_q        <= ptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_load && !store_full && in_q.present) begin
			col_min_q[col_sel] <= (in_q.value < mn) ? in_q.value : mn;
			col_max_q[col_sel] <= (in_q.value > mx) ? in_q.value : mx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_load && !store_full) begin
			store[count_base[AW-1:0]] <= {in_q.present, in_q.value};
		end
		if (cmd.mem_read) begin
			rd_q <= store[AW'(in_q.elem_index)];
		end
	end

	// classification of the fetched element
	assign rd_val   = $signed(rd_q[VALUE_W-1:0]);
	assign few_rows = int'(load_count_q) < 2 * int'(natt);
	assign pass     = !rd_q[VALUE_W] || few_rows;
	assign num      = {rd_val[VALUE_W-1], rd_val} - {mn[VALUE_W-1], mn};
	assign den      = {mx[VALUE_W-1], mx} - {mn[VALUE_W-1], mn};

	always_comb begin
		need_div = 1'b0;
		frac_fix = '0;
		priority if (pass) begin
			frac_fix = '0;
		end else if (mx <= mn) begin
			frac_fix = FRAC_HALF;
		end else if (rd_val <= mn) begin
			frac_fix = '0;
		end else if (rd_val >= mx) begin
			frac_fix = FRAC_ONE;
		end else begin
			need_div = 1'b1;
		end
	end

	// divider operands: remainder of index by column count, or the fraction
	assign div_start = cmd.div_mod_start || cmd.div_frac_start;

	always_comb begin
		if (cmd.div_frac_start) begin
			div_rem_init = num[VALUE_W-1:0];
			div_quo_init = '0;
			div_divisor  = den[VALUE_W-1:0];
			div_steps    = DIV_STEP_W'(FRACTION_BITS);
		end else begin
			div_rem_init = '0;
			div_quo_init = DIV_W'(in_q.elem_index) << (DIV_W - ELEM_INDEX_W);
			div_divisor  = VALUE_W'(natt);
			div_steps    = DIV_STEP_W'(ELEM_INDEX_W);
		end
	end

	mmn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.quo_init (div_quo_init),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.last     (div_last),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.set_error) begin
			res_err_q <= sts.is_error;
		end
		if (cmd.classify) begin
			res_pass_q <= pass;
			res_frac_q <= frac_fix;
			res_quot_q <= need_div;
		end
		if (cmd.load_out) begin
			out_q.index_error    <= res_err_q;
			out_q.raw_value      <= res_err_q ? '0 : rd_val;
			out_q.elem_present   <= res_err_q ? 1'b0 : rd_q[VALUE_W];
			out_q.passed_through <= res_err_q ? 1'b0 : res_pass_q;
			out_q.norm_fraction  <= res_err_q  ? '0 :
			                        res_quot_q ? FRAC_W'(div_quo[FRACTION_BITS-1:0]) :
			                                     res_frac_q;
		end
	end

	assign sts.is_error = int'(in_q.elem_index) >= int'(load_count_q);
	assign sts.need_div = need_div;
	assign sts.div_busy = div_busy;
	assign sts.div_last = div_last;
	assign out_item     = out_q;

endmodule

// ----- design/mmn_ctrl.sv -----
// Controller of the min-max normaliser: sequences loads and reads, owns the
// input ready and the output valid. Depends on mmn_pkg.
module mmn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_req_type,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mmn_pkg::sts_t    sts,
	output mmn_pkg::cmd_t    cmd,
	output mmn_pkg::state_t  state
);
	import mmn_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_req_type == REQ_READ) ? ST_FETCH : ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_IDLE;
			end
			ST_FETCH: begin
				state_d = sts.is_error ? ST_DELIVER : ST_COLUMN;
			end
			ST_COLUMN: begin
				if (sts.div_last) begin
					state_d = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				state_d = sts.need_div ? ST_DIVIDE : ST_DELIVER;
			end
			ST_DIVIDE: begin
				if (sts.div_last) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOAD: begin
				cmd.do_load = 1'b1;
			end
			ST_FETCH: begin
				cmd.mem_read      = 1'b1;
				cmd.set_error     = 1'b1;
				cmd.div_mod_start = !sts.is_error;
			end
			ST_COLUMN: begin
				cmd.col_from_rem = 1'b1;
			end
			ST_CLASSIFY: begin
				cmd.col_from_rem   = 1'b1;
				cmd.classify       = 1'b1;
				cmd.div_frac_start = sts.need_div;
			end
			ST_DIVIDE: begin
				cmd.col_from_rem = 1'b1;
			end
			ST_DELIVER: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

// ----- design/min_max_normaliser_core.sv -----
// Top level of the per-column min-max normaliser: controller, datapath and
// the checks on their interplay. Depends on mmn_pkg, mmn_ctrl, mmn_datapath.
//
//  channel | signals                        | direction | beat moves when
//  --------+--------------------------------+-----------+---------------------------
//  input   | in_valid, in_ready, in_item    | in        | in_valid && in_ready
//  output  | out_valid, out_ready, out_item | out       | out_valid && out_ready
//  config  | cfg_we, cfg_wdata              | in        | cfg_we (num_attributes)
//
// A load beat passes through the load state before the next beat is taken. A read
// beat goes fetch, column, classify, deliver when the fraction is fixed (pass-through,
// flat column, clamped value), with divide before deliver when it must be divided;
// an unknown index goes from fetch to deliver. The one serial restoring divider does
// 10 steps for the column (index modulo column count), 16 for the Q0.16 quotient.
// Reset is asynchronous and clears count, pointer, column valid bits and the
// column count (to one); the value store needs no clearing pass.
// A finished result waits in the output register while the next beat is
// accepted; a read only stalls in its final cycle if that register is still full.
module min_max_normaliser_core #(
	parameter int MAX_ATTRIBUTES = mmn_pkg::DEF_MAX_ATTRIBUTES,
	parameter int MAX_ELEMENTS   = mmn_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mmn_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mmn_pkg::out_item_t        out_item,
	input  logic                      cfg_we,
	input  logic [mmn_pkg::CFG_W-1:0] cfg_wdata
);
	import mmn_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	// sequence every beat: one item in flight, result held until taken
	mmn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (in_item.req_type),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sts         (sts),
		.cmd         (cmd),
		.state       (state)
	);

	// hold the store, the column extremes and the divider
	mmn_datapath #(
		.MAX_ATTRIBUTES (MAX_ATTRIBUTES),
		.MAX_ELEMENTS   (MAX_ELEMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

`ifndef SYNTH
	// a load beat never produces a result: it passes through the load state back to idle
	a_load_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.req_type == REQ_LOAD) |=> ##1 (state == ST_IDLE))
		else $error("load beat did not return to idle");

	// a read beat always goes to the fetch step first
	a_read_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.req_type == REQ_READ) |=> (state == ST_FETCH))
		else $error("read beat did not start a fetch");

	// the shared divider is left idle whenever the block waits for a beat
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_IDLE) |-> !sts.div_busy)
		else $error("divider busy while idle");

	// a result whose output slot is free is presented on the next edge
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_DELIVER && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
		else $error("result not delivered");
`endif

endmodule
